FILE: hdl/fcba_pkg.sv
// Shared types and constants for the chain block allocator.
package fcba_pkg;

    // Default table geometry
    localparam int NUM_BLOCKS_DEF    = 16384;
    localparam int LAST_RESERVED_DEF = 128;

    // Table entry: zero is free, END_MARK ends a chain, else next block
    localparam int                 ENTRY_W  = 16;
    localparam logic [ENTRY_W-1:0] END_MARK = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] FREE_ENT = 16'h0000;

    // Stream payload widths
    localparam int CNT_W      = 14;
    localparam int BLK_W      = 14;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Request kind carried on tuser
    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_SHORT   = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LINK_END,
        ST_WALK,
        ST_RESP
    } t_state;

endpackage

FILE: hdl/fcba_table.sv
// Allocation table memory: one write port, one registered read port.
module fcba_table #(
    parameter int DEPTH = fcba_pkg::NUM_BLOCKS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [fcba_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [fcba_pkg::ENTRY_W-1:0] o_rdata
);

    logic [fcba_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [fcba_pkg::ENTRY_W-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fat_chain_block_allocator.sv
// Chain block allocator: table controller, stream ports and result register.
//
// The block keeps a linked allocation table of NUM_BLOCKS 16-bit entries in a
// single synchronous RAM (zero = free, 0xFFFF = end of chain, else next block)
// plus a free block count. After reset it runs a clearing pass over the whole
// table, during which no request is taken; blocks 0..LAST_RESERVED come out
// holding the end mark. An allocate scans the table upward from block
// LAST_RESERVED+1 at one entry per cycle, the scan stopping at the last block
// taken; a free walks the chain at one link per cycle, clearing each entry,
// and stops at the end of the chain or on a link to a free entry. A refused
// allocate and a free of a reserved or out-of-range block go straight to the
// result; a free of a block that is already free is refused once its start
// entry has been read. Each request also waits while the previous result
// still holds the output register. The single read port of the table limits
// the scan and the walk to these rates. One request is in work at a time; a
// new one is taken while the previous result still waits on the output
// register.
module fat_chain_block_allocator #(
    parameter int NUM_BLOCKS    = fcba_pkg::NUM_BLOCKS_DEF,
    parameter int LAST_RESERVED = fcba_pkg::LAST_RESERVED_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [13:0] block_count, [27:14] start_block, [31:28] zero
    input  logic [fcba_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] kind
    input  logic                            i_s_tuser,
    // Result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [15:2] first_block, [29:16] free_blocks, [31:30] zero
    output logic [fcba_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int AW          = $clog2(NUM_BLOCKS);
    localparam int DATA_BLOCKS = NUM_BLOCKS - LAST_RESERVED - 1;
    localparam logic [AW-1:0] FIRST_DATA = AW'(LAST_RESERVED + 1);
    localparam logic [AW-1:0] LAST_BLK   = AW'(NUM_BLOCKS - 1);
    localparam logic [AW-1:0] DATA_MAX   = AW'(DATA_BLOCKS);
    localparam logic [16:0]   LO_EXT     = 17'(LAST_RESERVED + 1);
    localparam logic [16:0]   HI_EXT     = 17'(NUM_BLOCKS);
    localparam logic [16:0]   RES_EXT    = 17'(LAST_RESERVED);

    fcba_pkg::t_state  r_state, n_state;
    fcba_pkg::t_status r_status, n_status;
    logic [AW-1:0]               r_clr, n_clr;
    logic [AW-1:0]               r_free_count, n_free_count;
    logic [AW-1:0]               r_ptr, n_ptr;
    logic [AW-1:0]               r_prev, n_prev;
    logic [AW-1:0]               r_taken, n_taken;
    logic [AW-1:0]               r_first_blk, n_first_blk;
    logic [fcba_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_first, n_first;
    logic                        r_m_valid, n_m_valid;
    logic [fcba_pkg::OUT_DATA_W-1:0] r_m_data, n_m_data;

    // Table port
    logic                         tbl_we;
    logic [AW-1:0]                tbl_waddr;
    logic [fcba_pkg::ENTRY_W-1:0] tbl_wdata;
    logic [AW-1:0]                tbl_raddr;
    logic [fcba_pkg::ENTRY_W-1:0] tbl_rdata;

    // Request decode
    logic                       s_acc;
    fcba_pkg::t_kind            in_kind;
    logic [fcba_pkg::CNT_W-1:0] in_cnt;
    logic [16:0]                in_start_ext;
    logic                       cnt_zero, cnt_short, start_ok;
    logic                       scan_hit, scan_done;
    logic                       walk_zero, walk_stop, link_ok;
    logic [16:0]                rd_ext;
    logic                       resp_go;
    logic [15:0]                free_ext, first_ext;

    assign s_acc        = i_s_tvalid && o_s_tready;
    assign in_kind      = fcba_pkg::t_kind'(i_s_tuser);
    assign in_cnt       = i_s_tdata[13:0];
    assign in_start_ext = 17'(i_s_tdata[27:14]);
    assign cnt_zero     = (in_cnt == '0);
    assign cnt_short    = (16'(in_cnt) > 16'(r_free_count));
    assign start_ok     = (in_start_ext >= LO_EXT) && (in_start_ext < HI_EXT);

    // Scan and walk decisions on the entry read last cycle
    assign scan_hit  = (tbl_rdata == fcba_pkg::FREE_ENT);
    assign scan_done = (scan_hit && (16'(r_taken) + 16'd1 == 16'(r_count)))
                       || (r_ptr == LAST_BLK);
    assign rd_ext    = 17'(tbl_rdata);
    assign link_ok   = (rd_ext >= LO_EXT) && (rd_ext < HI_EXT);
    assign walk_zero = (tbl_rdata == fcba_pkg::FREE_ENT);
    assign walk_stop = !link_ok || (AW'(tbl_rdata) == r_ptr);

    assign resp_go   = !r_m_valid || i_m_tready;
    assign free_ext  = 16'(r_free_count);
    assign first_ext = 16'(r_first_blk);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fcba_pkg::ST_CLEAR: begin
                if (r_clr == LAST_BLK) n_state = fcba_pkg::ST_IDLE;
            end
            fcba_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (in_kind == fcba_pkg::KIND_FREE) begin
                        n_state = start_ok ? fcba_pkg::ST_WALK : fcba_pkg::ST_RESP;
                    end else begin
                        n_state = (cnt_zero || cnt_short) ? fcba_pkg::ST_RESP
                                                          : fcba_pkg::ST_SCAN;
                    end
                end
            end
            fcba_pkg::ST_SCAN: begin
                if (scan_done) n_state = fcba_pkg::ST_LINK_END;
            end
            fcba_pkg::ST_LINK_END: begin
                n_state = fcba_pkg::ST_RESP;
            end
            fcba_pkg::ST_WALK: begin
                if (walk_zero || walk_stop) n_state = fcba_pkg::ST_RESP;
            end
            fcba_pkg::ST_RESP: begin
                if (resp_go) n_state = fcba_pkg::ST_IDLE;
            end
            default: n_state = fcba_pkg::ST_IDLE;
        endcase
    end

    // Datapath, table accesses and result
    always_comb begin
        n_status     = r_status;
        n_clr        = r_clr;
        n_free_count = r_free_count;
        n_ptr        = r_ptr;
        n_prev       = r_prev;
        n_taken      = r_taken;
        n_first_blk  = r_first_blk;
        n_count      = r_count;
        n_first      = r_first;
        n_m_valid    = r_m_valid && !i_m_tready;
        n_m_data     = r_m_data;
        tbl_we       = 1'b0;
        tbl_waddr    = r_ptr;
        tbl_wdata    = fcba_pkg::FREE_ENT;
        tbl_raddr    = r_ptr;
        unique case (r_state)
            fcba_pkg::ST_CLEAR: begin
                // Fill reserved entries with end mark, the rest with zero
                tbl_we    = 1'b1;
                tbl_waddr = r_clr;
                tbl_wdata = (17'(r_clr) <= RES_EXT) ? fcba_pkg::END_MARK
                                                     : fcba_pkg::FREE_ENT;
                n_clr     = r_clr + 1'b1;
            end
            fcba_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_count     = in_cnt;
                    n_taken     = '0;
                    n_first_blk = '0;
                    n_first     = 1'b1;
                    n_status    = fcba_pkg::STAT_OK;
                    if (in_kind == fcba_pkg::KIND_FREE) begin
                        // Read the start entry, or refuse a bad start block
                        n_ptr     = AW'(in_start_ext);
                        tbl_raddr = AW'(in_start_ext);
                        if (!start_ok) n_status = fcba_pkg::STAT_INVALID;
                    end else begin
                        // Start the scan at the first data block
                        n_ptr     = FIRST_DATA;
                        tbl_raddr = FIRST_DATA;
                        if (cnt_zero) begin
                            n_status = fcba_pkg::STAT_INVALID;
                        end else if (cnt_short) begin
                            n_status = fcba_pkg::STAT_SHORT;
                        end
                    end
                end
            end
            fcba_pkg::ST_SCAN: begin
                // Take a free entry and link the previous one to it
                if (scan_hit) begin
                    if (r_taken != '0) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = r_prev;
                        tbl_wdata = fcba_pkg::ENTRY_W'(r_ptr);
                    end else begin
                        n_first_blk = r_ptr;
                    end
                    n_prev  = r_ptr;
                    n_taken = r_taken + 1'b1;
                end
                // Advance to the next entry
                if (!scan_done) begin
                    n_ptr     = r_ptr + 1'b1;
                    tbl_raddr = r_ptr + 1'b1;
                end
            end
            fcba_pkg::ST_LINK_END: begin
                // Close the chain and charge the free count
                if (r_taken != '0) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_prev;
                    tbl_wdata = fcba_pkg::END_MARK;
                end else begin
                    n_first_blk = '0;
                end
                n_free_count = r_free_count - r_taken;
                n_status     = fcba_pkg::STAT_OK;
            end
            fcba_pkg::ST_WALK: begin
                if (walk_zero) begin
                    // Already free: refuse at the start, else stop the walk
                    n_status = r_first ? fcba_pkg::STAT_INVALID : fcba_pkg::STAT_OK;
                end else begin
                    // Clear this entry and follow its link
                    tbl_we    = 1'b1;
                    tbl_waddr = r_ptr;
                    tbl_wdata = fcba_pkg::FREE_ENT;
                    if (r_free_count < DATA_MAX) n_free_count = r_free_count + 1'b1;
                    n_status  = fcba_pkg::STAT_OK;
                    n_first   = 1'b0;
                    if (!walk_stop) begin
                        n_ptr     = AW'(tbl_rdata);
                        tbl_raddr = AW'(tbl_rdata);
                    end
                end
            end
            fcba_pkg::ST_RESP: begin
                // Load the result beat once the output register is free
                if (resp_go) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {2'b00, free_ext[13:0], first_ext[13:0], r_status};
                end
            end
            default: begin
                n_m_valid = r_m_valid && !i_m_tready;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fcba_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_free_count <= DATA_MAX;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_free_count <= n_free_count;
            r_m_valid    <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_ptr       <= n_ptr;
        r_prev      <= n_prev;
        r_taken     <= n_taken;
        r_first_blk <= n_first_blk;
        r_count     <= n_count;
        r_first     <= n_first;
        r_m_data    <= n_m_data;
    end

    fcba_table #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign o_s_tready = (r_state == fcba_pkg::ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Free count stays within the data area
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= DATA_MAX)
        else $error("free count above data block count");

    // No result while the table is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcba_pkg::ST_CLEAR) |-> !r_m_valid)
        else $error("result during clearing pass");

    // The scan never takes more blocks than requested
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcba_pkg::ST_SCAN) |-> (16'(r_taken) < 16'(r_count)))
        else $error("scan overran request");

    // Reserved entries are never written after clearing
    a_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_we && (r_state != fcba_pkg::ST_CLEAR)) |-> (17'(tbl_waddr) >= LO_EXT))
        else $error("write into reserved area");

    // An accepted request leaves idle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != fcba_pkg::ST_IDLE))
        else $error("request accepted without work");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the chain block allocator: in-order prediction of every request.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcba_pkg::*;

    localparam int NUM_BLOCKS    = NUM_BLOCKS_DEF;
    localparam int FIRST_DATA    = LAST_RESERVED_DEF + 1;
    localparam int DATA_BLOCKS   = NUM_BLOCKS_DEF - LAST_RESERVED_DEF - 1;
    localparam int MAX_FIELD     = (1 << BLK_W) - 1;
    localparam int RANDOM_ITEMS  = 1580;
    localparam int CALM_ITEMS    = 150;
    localparam int LIVE_CAP      = 240;
    localparam int DRAIN_CYCLES  = 16;
    localparam longint CYCLE_LIMIT = 4_000_000;

    // One result beat as the block should produce it
    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] first_block;
        logic [CNT_W-1:0] free_blocks;
    } alloc_result_t;

    // Shadow allocation table plus the results still owed by the block
    class alloc_scoreboard;
        logic [ENTRY_W-1:0] fat [NUM_BLOCKS];
        int unsigned        free_cnt;
        alloc_result_t      pending [$];
        int unsigned        errors;

        function new();
            for (int i = 0; i < NUM_BLOCKS; i++)
                fat[i] = (i < FIRST_DATA) ? END_MARK : FREE_ENT;
            free_cnt = DATA_BLOCKS;
            errors   = 0;
        endfunction

        function logic [ENTRY_W-1:0] link_of(int unsigned b);
            return fat[b];
        endfunction

        function bit is_data(int unsigned b);
            return b >= FIRST_DATA && b < NUM_BLOCKS;
        endfunction

        // Apply one accepted request to the shadow table and queue its result
        function alloc_result_t note_request(t_kind kind, logic [CNT_W-1:0] count,
                                             logic [BLK_W-1:0] start);
            alloc_result_t      r;
            int unsigned        taken;
            int unsigned        prev;
            int unsigned        b;
            logic [ENTRY_W-1:0] nxt;
            bit                 done;
            r.status      = STAT_OK;
            r.first_block = '0;
            if (kind == KIND_ALLOC) begin
                if (count == 0) begin
                    r.status = STAT_INVALID;
                end else if (count > free_cnt) begin
                    r.status = STAT_SHORT;
                end else begin
                    taken = 0;
                    prev  = 0;
                    // take free entries upward and link each to the next one found
                    for (int unsigned j = FIRST_DATA; j < NUM_BLOCKS && taken < count; j++) begin
                        if (fat[j] == FREE_ENT) begin
                            if (taken == 0)
                                r.first_block = BLK_W'(j);
                            else
                                fat[prev] = ENTRY_W'(j);
                            fat[j] = END_MARK;
                            prev   = j;
                            taken++;
                        end
                    end
                    free_cnt -= taken;
                end
            end else begin
                if (!is_data(start) || fat[start] == FREE_ENT) begin
                    r.status = STAT_INVALID;
                end else begin
                    // walk and clear, stop on end mark, bad link or free target
                    b    = start;
                    done = 1'b0;
                    for (int unsigned steps = 0; steps < NUM_BLOCKS && !done; steps++) begin
                        nxt    = fat[b];
                        fat[b] = FREE_ENT;
                        if (free_cnt < DATA_BLOCKS)
                            free_cnt++;
                        if (nxt == END_MARK || !is_data(nxt) || fat[nxt] == FREE_ENT)
                            done = 1'b1;
                        else
                            b = nxt;
                    end
                end
            end
            r.free_blocks = CNT_W'(free_cnt);
            pending.push_back(r);
            return r;
        endfunction

        // Compare one result beat with the oldest outstanding result
        function void check_result(logic [OUT_DATA_W-1:0] beat);
            alloc_result_t want;
            if (pending.size() == 0) begin
                $error("result beat %h with no request outstanding", beat);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (beat[1:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, beat[1:0]);
                errors++;
            end
            if (beat[15:2] !== want.first_block) begin
                $error("first_block: expected %0d, got %0d", want.first_block, beat[15:2]);
                errors++;
            end
            if (beat[29:16] !== want.free_blocks) begin
                $error("free_blocks: expected %0d, got %0d", want.free_blocks, beat[29:16]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic [IN_DATA_W-1:0]  req_data  = '0;
    logic                  req_kind  = 1'b0;
    logic                  rsp_ready = 1'b0;
    logic                  req_ready;
    logic                  rsp_valid;
    logic [OUT_DATA_W-1:0] rsp_data;

    alloc_scoreboard sb;
    logic [BLK_W-1:0] heads [$];
    bit               calm  = 1'b0;
    bit               gappy = 1'b1;
    longint           cycle_cnt = 0;

    fat_chain_block_allocator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (req_valid),
        .o_s_tready (req_ready),
        .i_s_tdata  (req_data),   // [13:0] block_count, [27:14] start_block, [31:28] zero
        .i_s_tuser  (req_kind),   // [0] kind
        .o_m_tvalid (rsp_valid),
        .i_m_tready (rsp_ready),
        .o_m_tdata  (rsp_data)    // [1:0] status, [15:2] first_block, [29:16] free_blocks
    );

    always #1 clk = ~clk;

    // Bound the run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Check every accepted result beat
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
    end

    // Stall the result side in bursts, hold ready steady once calm
    initial begin : rsp_stall
        int unsigned burst;
        forever begin
            if (calm) begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end else begin
                burst = $urandom_range(1, 9);
                rsp_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                burst = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
                rsp_ready <= 1'b1;
                repeat (burst) @(posedge clk);
            end
        end
    end

    // Drive one request beat, wait for acceptance and predict its result
    task automatic send_request(input t_kind kind, input logic [CNT_W-1:0] count,
                                input logic [BLK_W-1:0] start);
        alloc_result_t res;
        int unsigned   gap_len;
        if (!calm && gappy && $urandom_range(3) == 0) begin
            gap_len = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_data  <= {4'b0, start, count};
        do @(posedge clk); while (!req_ready);
        res = sb.note_request(kind, count, start);
        if (kind == KIND_ALLOC && res.status == STAT_OK)
            heads.push_back(res.first_block);
    endtask

    function automatic logic [BLK_W-1:0] any_field();
        return BLK_W'($urandom_range(MAX_FIELD));
    endfunction

    initial begin : stimulus
        int unsigned        pick;
        int unsigned        live;
        int unsigned        idx;
        int unsigned        hops;
        logic [CNT_W-1:0]   cnt;
        logic [BLK_W-1:0]   blk;
        logic [ENTRY_W-1:0] nxt;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Refusals on a fresh table
        send_request(KIND_ALLOC, '0, any_field());
        send_request(KIND_ALLOC, CNT_W'(MAX_FIELD), any_field());
        send_request(KIND_ALLOC, CNT_W'(DATA_BLOCKS + 1), any_field());
        send_request(KIND_FREE, any_field(), '0);
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA - 1));
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA));
        send_request(KIND_FREE, any_field(), BLK_W'(MAX_FIELD));
        // Small chains, then free a tail and let a new chain fill the hole
        send_request(KIND_ALLOC, 14'd1, any_field());
        send_request(KIND_ALLOC, 14'd5, any_field());
        send_request(KIND_ALLOC, 14'd3, any_field());
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA + 3));
        send_request(KIND_ALLOC, 14'd2, any_field());
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA + 1));
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA));
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA + 6));
        // Fill the whole table, free and retake the top block, then drain it from the first data block
        send_request(KIND_ALLOC, CNT_W'(DATA_BLOCKS), any_field());
        send_request(KIND_ALLOC, 14'd1, any_field());
        send_request(KIND_FREE, any_field(), BLK_W'(MAX_FIELD));
        send_request(KIND_ALLOC, 14'd1, any_field());
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA));
        send_request(KIND_FREE, any_field(), BLK_W'(FIRST_DATA));
        heads.delete();

        // Random traffic: mostly well-formed allocate/free pairs, some noise
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % 40 == 0)
                gappy = ($urandom_range(2) != 0);
            if (item >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            live = DATA_BLOCKS - sb.free_cnt;
            pick = $urandom_range(99);
            if (live > LIVE_CAP && heads.size() > 0)
                pick = 50;
            if (pick < 45) begin
                cnt = ($urandom_range(49) == 0) ? CNT_W'($urandom_range(9, 1200))
                                                : CNT_W'($urandom_range(1, 8));
                send_request(KIND_ALLOC, cnt, any_field());
            end else if (pick < 83 && heads.size() > 0) begin
                idx = $urandom_range(heads.size() - 1);
                blk = heads[idx];
                if (pick < 75 || sb.link_of(blk) == FREE_ENT) begin
                    heads.delete(idx);
                end else begin
                    // step into the chain and free its tail only
                    hops = $urandom_range(1, 4);
                    repeat (hops) begin
                        nxt = sb.link_of(blk);
                        if (nxt == END_MARK || nxt < FIRST_DATA || nxt >= NUM_BLOCKS ||
                            sb.link_of(nxt) == FREE_ENT)
                            break;
                        blk = BLK_W'(nxt);
                    end
                end
                send_request(KIND_FREE, any_field(), blk);
            end else if (pick < 90) begin
                blk = ($urandom_range(1) == 0) ? any_field()
                      : BLK_W'($urandom_range(FIRST_DATA, FIRST_DATA + 300));
                send_request(KIND_FREE, any_field(), blk);
            end else if (pick < 95) begin
                cnt = CNT_W'($urandom_range(sb.free_cnt + 1, MAX_FIELD));
                send_request(KIND_ALLOC, cnt, any_field());
            end else if (pick < 97) begin
                send_request(KIND_ALLOC, '0, any_field());
            end else begin
                send_request(KIND_FREE, any_field(), BLK_W'($urandom_range(FIRST_DATA - 1)));
            end
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
